### sv/pgsct_pkg.sv
package pgsct_pkg;

  // fraction bits of the fixed point format by default
  localparam int unsigned FracBitsDef = 16;

  // data width of the configuration port and of every field word
  localparam int unsigned WordW = 32;

  // width of a quotient numerator magnitude and of its denominator
  localparam int unsigned NumW = 34;

  // width of the radicand and of its integer root
  localparam int unsigned RadW  = 64;
  localparam int unsigned RootW = 32;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgSlope    = 2'd0,
    CfgRadStart = 2'd1,
    CfgStepT0   = 2'd2,
    CfgStepT1   = 2'd3
  } cfg_idx_e;

endpackage

### sv/pgsct_sqrt.sv
module pgsct_sqrt #(
  parameter int unsigned SideW = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [pgsct_pkg::RadW-1:0]   rad_i,
  input  logic [SideW-1:0]             side_i,
  output logic                         valid_o,
  output logic [pgsct_pkg::RootW-1:0]  root_o,
  output logic [SideW-1:0]             side_o
);
  import pgsct_pkg::*;

  localparam int unsigned RemW = RootW + 4;

  // one root bit per stage, two radicand bits consumed per stage
  logic                vld_q  [RootW+1];
  logic [RadW-1:0]     rad_q  [RootW+1];
  logic [RemW-1:0]     rem_q  [RootW+1];
  logic [RootW-1:0]    root_q [RootW+1];
  logic [SideW-1:0]    side_q [RootW+1];

  assign vld_q[0]  = valid_i;
  assign rad_q[0]  = rad_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW-1:0]  rem_n;
    logic [RemW-1:0]  trial;
    logic [RemW-1:0]  rem_d;
    logic [RootW-1:0] root_d;

    // restoring step: trial subtract of 4*root+1
    always_comb begin
      rem_n = {rem_q[k][RemW-3:0], rad_q[k][RadW-1 -: 2]};
      trial = {2'b00, root_q[k], 2'b01};
      if (rem_n >= trial) begin
        rem_d  = rem_n - trial;
        root_d = {root_q[k][RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_n;
        root_d = {root_q[k][RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k+1]  <= {rad_q[k][RadW-3:0], 2'b00};
      rem_q[k+1]  <= rem_d;
      root_q[k+1] <= root_d;
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = vld_q[RootW];
  assign root_o  = root_q[RootW];
  assign side_o  = side_q[RootW];

endmodule

### sv/pgsct_div.sv
module pgsct_div #(
  parameter int unsigned MagW  = 50,
  parameter int unsigned SideW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [MagW-1:0]             dividend_i,
  input  logic [pgsct_pkg::NumW-1:0]  divisor_i,
  input  logic [SideW-1:0]            side_i,
  output logic                        valid_o,
  output logic [MagW-1:0]             quot_o,
  output logic [SideW-1:0]            side_o
);
  import pgsct_pkg::*;

  // one quotient bit per stage, most significant first
  logic              vld_q [MagW+1];
  logic [MagW-1:0]   num_q [MagW+1];
  logic [NumW-1:0]   den_q [MagW+1];
  logic [NumW-1:0]   rem_q [MagW+1];
  logic [MagW-1:0]   quo_q [MagW+1];
  logic [SideW-1:0]  side_q [MagW+1];

  assign vld_q[0]  = valid_i;
  assign num_q[0]  = dividend_i;
  assign den_q[0]  = divisor_i;
  assign rem_q[0]  = '0;
  assign quo_q[0]  = '0;
  assign side_q[0] = side_i;

  for (genvar k = 0; k < MagW; k++) begin : g_stage
    logic [NumW:0]   rem_n;
    logic [NumW-1:0] rem_d;
    logic            bit_d;

    // restoring step against the divisor
    always_comb begin
      rem_n = {rem_q[k], num_q[k][MagW-1]};
      if (rem_n >= {1'b0, den_q[k]}) begin
        rem_d = NumW'(rem_n - {1'b0, den_q[k]});
        bit_d = 1'b1;
      end else begin
        rem_d = rem_n[NumW-1:0];
        bit_d = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k+1]  <= {num_q[k][MagW-2:0], 1'b0};
      den_q[k+1]  <= den_q[k];
      rem_q[k+1]  <= rem_d;
      quo_q[k+1]  <= {quo_q[k][MagW-2:0], bit_d};
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = vld_q[MagW];
  assign quot_o  = quo_q[MagW];
  assign side_o  = side_q[MagW];

endmodule

### sv/particle_growing_sphere_crossing_time_core.sv
// channel   | handshake          | payload
// ----------+--------------------+--------------------------------------------
// input     | start_i, busy_o    | pos_x/y/z_i, vel_x/y/z_i, sample_time_i
// result    | done_o (strobe)    | crossing_time_o, crossing_found_o
// config    | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// one word enters per cycle; busy_o is always low
// the pipeline has six product and coefficient stages, 32 root stages,
// 34 + FRAC_BITS divider stages, plus input, operand and output registers
// reset clears the valid bits and the configuration registers
// the receiver cannot stall, so every stage advances on every clock
module particle_growing_sphere_crossing_time_core #(
  parameter int unsigned FRAC_BITS = pgsct_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [pgsct_pkg::WordW-1:0]        cfg_data_i,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [pgsct_pkg::WordW-1:0] pos_x_i,
  input  logic signed [pgsct_pkg::WordW-1:0] pos_y_i,
  input  logic signed [pgsct_pkg::WordW-1:0] pos_z_i,
  input  logic signed [pgsct_pkg::WordW-1:0] vel_x_i,
  input  logic signed [pgsct_pkg::WordW-1:0] vel_y_i,
  input  logic signed [pgsct_pkg::WordW-1:0] vel_z_i,
  input  logic signed [pgsct_pkg::WordW-1:0] sample_time_i,
  output logic                               done_o,
  output logic signed [pgsct_pkg::WordW-1:0] crossing_time_o,
  output logic                               crossing_found_o
);
  import pgsct_pkg::*;

  localparam int unsigned SumW  = 67;
  localparam int unsigned MagW  = NumW + FRAC_BITS;
  localparam int unsigned TimeW = MagW + 2;
  localparam int unsigned SqSideW  = 4 * WordW + 1;
  localparam int unsigned DivSideW = WordW + 2;
  localparam logic signed [SumW-1:0] CoefMax = SumW'(64'sh7FFF_FFFF);
  localparam logic signed [SumW-1:0] CoefMin = -CoefMax;
  localparam logic signed [SumW-1:0] WordMin = SumW'(-64'sh8000_0000);
  localparam logic signed [TimeW-1:0] TimeMax = TimeW'(64'sh7FFF_FFFF);
  localparam logic signed [TimeW-1:0] TimeMin = TimeW'(-64'sh8000_0000);

  // configuration registers
  logic signed [WordW-1:0] slope_q, t0_q, t1_q;
  logic        [WordW-2:0] r0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q <= '0;
      r0_q    <= '0;
      t0_q    <= '0;
      t1_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSlope:    slope_q <= cfg_data_i;
        CfgRadStart: r0_q    <= cfg_data_i[WordW-2:0];
        CfgStepT0:   t0_q    <= cfg_data_i;
        CfgStepT1:   t1_q    <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage 0: input word
  logic                    v0_q;
  logic signed [WordW-1:0] px0_q, py0_q, pz0_q, vx0_q, vy0_q, vz0_q, ts0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    px0_q <= pos_x_i;
    py0_q <= pos_y_i;
    pz0_q <= pos_z_i;
    vx0_q <= vel_x_i;
    vy0_q <= vel_y_i;
    vz0_q <= vel_z_i;
    ts0_q <= sample_time_i;
  end

  // stage 1: all first products
  logic                    v1_q;
  logic signed [WordW:0]   dt1;
  logic signed [64:0]      krdt1_q;
  logic signed [63:0]      vxx1_q, vyy1_q, vzz1_q, krkr1_q;
  logic signed [63:0]      pvx1_q, pvy1_q, pvz1_q, pxx1_q, pyy1_q, pzz1_q;
  logic signed [WordW-1:0] ts1_q;

  assign dt1 = (WordW+1)'(ts0_q) - (WordW+1)'(t0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    krdt1_q <= slope_q * dt1;
    vxx1_q  <= vx0_q * vx0_q;
    vyy1_q  <= vy0_q * vy0_q;
    vzz1_q  <= vz0_q * vz0_q;
    krkr1_q <= slope_q * slope_q;
    pvx1_q  <= px0_q * vx0_q;
    pvy1_q  <= py0_q * vy0_q;
    pvz1_q  <= pz0_q * vz0_q;
    pxx1_q  <= px0_q * px0_q;
    pyy1_q  <= py0_q * py0_q;
    pzz1_q  <= pz0_q * pz0_q;
    ts1_q   <= ts0_q;
  end

  // stage 2: radius at sample time and partial coefficient sums
  logic                    v2_q, ok2_q;
  logic signed [SumW-1:0]  sr2, a2, pv2, pp2;
  logic signed [SumW-1:0]  a2_q, pv2_q, pp2_q;
  logic signed [WordW-1:0] sr2_q, ts2_q;

  always_comb begin
    sr2 = $signed(SumW'({1'b0, r0_q})) + SumW'(krdt1_q >>> FRAC_BITS);
    a2  = SumW'(vxx1_q >>> FRAC_BITS) + SumW'(vyy1_q >>> FRAC_BITS)
        + SumW'(vzz1_q >>> FRAC_BITS) - SumW'(krkr1_q >>> FRAC_BITS);
    pv2 = SumW'(pvx1_q >>> FRAC_BITS) + SumW'(pvy1_q >>> FRAC_BITS)
        + SumW'(pvz1_q >>> FRAC_BITS);
    pp2 = SumW'(pxx1_q >>> FRAC_BITS) + SumW'(pyy1_q >>> FRAC_BITS)
        + SumW'(pzz1_q >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok2_q <= (sr2 >= WordMin) && (sr2 <= CoefMax);
    sr2_q <= sr2[WordW-1:0];
    a2_q  <= a2;
    pv2_q <= pv2;
    pp2_q <= pp2;
    ts2_q <= ts1_q;
  end

  // stage 3: radius products
  logic                    v3_q, ok3_q;
  logic signed [63:0]      srkr3_q, srsr3_q;
  logic signed [SumW-1:0]  a3_q, pv3_q, pp3_q;
  logic signed [WordW-1:0] ts3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    srkr3_q <= sr2_q * slope_q;
    srsr3_q <= sr2_q * sr2_q;
    ok3_q   <= ok2_q;
    a3_q    <= a2_q;
    pv3_q   <= pv2_q;
    pp3_q   <= pp2_q;
    ts3_q   <= ts2_q;
  end

  // stage 4: coefficients b and c, range check
  logic                    v4_q, ok4_q;
  logic signed [SumW-1:0]  b4, c4;
  logic signed [WordW-1:0] a4_q, b4_q, c4_q, ts4_q;

  assign b4 = pv3_q - SumW'(srkr3_q >>> FRAC_BITS);
  assign c4 = pp3_q - SumW'(srsr3_q >>> FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok4_q <= ok3_q
          && (a3_q <= CoefMax) && (a3_q >= CoefMin)
          && (b4 <= CoefMax) && (b4 >= CoefMin)
          && (c4 <= CoefMax) && (c4 >= CoefMin);
    a4_q  <= a3_q[WordW-1:0];
    b4_q  <= b4[WordW-1:0];
    c4_q  <= c4[WordW-1:0];
    ts4_q <= ts3_q;
  end

  // stage 5: discriminant products
  logic                    v5_q, ok5_q;
  logic signed [63:0]      bb5_q, ac5_q;
  logic signed [WordW-1:0] a5_q, b5_q, c5_q, ts5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bb5_q <= b4_q * b4_q;
    ac5_q <= a4_q * c4_q;
    ok5_q <= ok4_q;
    a5_q  <= a4_q;
    b5_q  <= b4_q;
    c5_q  <= c4_q;
    ts5_q <= ts4_q;
  end

  // stage 6: discriminant and root case
  logic                    v6_q, go6_q;
  logic signed [64:0]      d6;
  logic [RadW-1:0]         d6_q;
  logic signed [WordW-1:0] a6_q, b6_q, c6_q, ts6_q;

  assign d6 = 65'(bb5_q) - 65'(ac5_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    go6_q <= ok5_q && !d6[64] && ((a5_q > 0) || (b5_q > 0));
    d6_q  <= d6[RadW-1:0];
    a6_q  <= a5_q;
    b6_q  <= b5_q;
    c6_q  <= c5_q;
    ts6_q <= ts5_q;
  end

  // integer square root of the discriminant
  logic                    vs;
  logic [RootW-1:0]        s_root;
  logic [SqSideW-1:0]      sq_side;
  logic signed [WordW-1:0] as, bs, cs, tss;
  logic                    gos;

  pgsct_sqrt #(
    .SideW (SqSideW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v6_q),
    .rad_i   (d6_q),
    .side_i  ({a6_q, b6_q, c6_q, ts6_q, go6_q}),
    .valid_o (vs),
    .root_o  (s_root),
    .side_o  (sq_side)
  );

  assign {as, bs, cs, tss, gos} = sq_side;

  // stable root choice: numerator and denominator of the quotient
  logic                    vp_q, okp_q, negp_q;
  logic signed [NumW:0]    nump;
  logic [NumW-1:0]         denp, magp;
  logic [MagW-1:0]         dvdp_q;
  logic [NumW-1:0]         denp_q;
  logic signed [WordW-1:0] tsp_q;

  always_comb begin
    if (bs > 0) begin
      nump = -(NumW+1)'(cs);
      denp = NumW'($unsigned(bs)) + NumW'(s_root);
    end else begin
      nump = $signed((NumW+1)'(s_root)) - (NumW+1)'(bs);
      denp = NumW'($unsigned(as));
    end
    magp = nump[NumW] ? NumW'(-nump) : nump[NumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    dvdp_q <= {magp, {FRAC_BITS{1'b0}}};
    denp_q <= denp;
    negp_q <= nump[NumW];
    okp_q  <= gos;
    tsp_q  <= tss;
  end

  // long division, one quotient bit a stage
  logic                    vq;
  logic [MagW-1:0]         quot;
  logic [DivSideW-1:0]     div_side;
  logic signed [WordW-1:0] tsq;
  logic                    okq, negq;

  pgsct_div #(
    .MagW  (MagW),
    .SideW (DivSideW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vp_q),
    .dividend_i (dvdp_q),
    .divisor_i  (denp_q),
    .side_i     ({tsp_q, okp_q, negp_q}),
    .valid_o    (vq),
    .quot_o     (quot),
    .side_o     (div_side)
  );

  assign {tsq, okq, negq} = div_side;

  // absolute time, range and step end check
  logic signed [TimeW-1:0] tq, tmq;
  logic                    fnd;

  always_comb begin
    tq  = negq ? -$signed(TimeW'(quot)) : $signed(TimeW'(quot));
    tmq = TimeW'(tsq) + tq;
    fnd = okq && (tmq >= TimeMin) && (tmq <= TimeMax) && (tmq <= TimeW'(t1_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vq;
    end
  end

  always_ff @(posedge clk_i) begin
    crossing_time_o  <= fnd ? tmq[WordW-1:0] : '0;
    crossing_found_o <= fnd;
  end

endmodule

### tb/tb_particle_growing_sphere_crossing_time_core.sv
module tb_particle_growing_sphere_crossing_time_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pgsct_pkg::*;

  localparam int unsigned FB = FracBitsDef;
  localparam int unsigned LATENCY = 75 + FB;
  localparam int NumRandom = 1900;

  typedef struct packed {
    logic signed [31:0] px, py, pz, vx, vy, vz, ts;
  } particle_t;

  typedef struct packed {
    logic signed [31:0] tm;
    logic               found;
  } crossing_t;

  // directed row: a word plus an optional typed-in answer
  typedef struct {
    particle_t p;
    bit        typed;
    crossing_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [WordW-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic signed [31:0] sample_time_i = '0;
  logic done_o;
  logic signed [31:0] crossing_time_o;
  logic crossing_found_o;

  // local copy of the bubble registers
  longint slope_q, rad0_q, t0_q, t1_q;

  crossing_t crossings_pending[$];
  int failures = 0;

  particle_growing_sphere_crossing_time_core #(.FRAC_BITS(FB)) i_dut (.*);

  always #10 clk_i = ~clk_i;

  // floor division by 2^FB on 128 bits
  function automatic longint fix_floor(logic signed [127:0] x);
    logic signed [127:0] y;
    y = x >>> FB;
    return longint'(y);
  endfunction

  function automatic longint int_root(logic [63:0] n);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic bit coef_fits(longint x);
    return x <= 64'sh7FFFFFFF && x >= -64'sh7FFFFFFF;
  endfunction

  // expected crossing of one particle with the growing wall
  function automatic crossing_t wall_crossing(particle_t p);
    crossing_t r;
    longint px, py, pz, vx, vy, vz, ts, sr, a, b, c, s, t, tm;
    logic signed [127:0] d, num;
    px = p.px; py = p.py; pz = p.pz; vx = p.vx; vy = p.vy; vz = p.vz; ts = p.ts;
    r = '0;
    sr = rad0_q + fix_floor(128'(slope_q) * 128'(ts - t0_q));
    if (sr < -64'sh80000000 || sr > 64'sh7FFFFFFF) return r;
    a = fix_floor(vx * vx) + fix_floor(vy * vy) + fix_floor(vz * vz)
        - fix_floor(slope_q * slope_q);
    b = fix_floor(px * vx) + fix_floor(py * vy) + fix_floor(pz * vz)
        - fix_floor(sr * slope_q);
    c = fix_floor(px * px) + fix_floor(py * py) + fix_floor(pz * pz)
        - fix_floor(sr * sr);
    if (!(coef_fits(a) && coef_fits(b) && coef_fits(c))) return r;
    d = 128'(b) * 128'(b) - 128'(a) * 128'(c);
    if (d < 0 || !(a > 0 || b > 0)) return r;
    s = int_root(d[63:0]);
    if (b > 0) begin
      num = 128'(-c) <<< FB;
      t = longint'(num / 128'(b + s));
    end else begin
      num = 128'(s - b) <<< FB;
      t = longint'(num / 128'(a));
    end
    tm = ts + t;
    if (tm >= -64'sh80000000 && tm <= 64'sh7FFFFFFF && tm <= t1_q) begin
      r.tm = tm[31:0];
      r.found = 1'b1;
    end
    return r;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgSlope:    slope_q = longint'(signed'(val));
      CfgRadStart: rad0_q  = longint'(val[30:0]);
      CfgStepT0:   t0_q    = longint'(signed'(val));
      CfgStepT1:   t1_q    = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic set_bubble(logic [31:0] k, logic [31:0] r0, logic [31:0] s0,
                            logic [31:0] s1);
    write_reg(CfgSlope, k);
    write_reg(CfgRadStart, r0);
    write_reg(CfgStepT0, s0);
    write_reg(CfgStepT1, s1);
  endtask

  // drain, then let the pipe empty before touching the registers
  task automatic wait_idle();
    while (crossings_pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // one word, start held high across back-to-back words
  task automatic send_particle(particle_t p, bit more);
    start_i <= 1'b1;
    {pos_x_i, pos_y_i, pos_z_i, vel_x_i, vel_y_i, vel_z_i, sample_time_i} <= p;
    do @(posedge clk_i); while (busy_o);
    crossings_pending = {crossings_pending, wall_crossing(p)};
    if (!more) start_i <= 1'b0;
  endtask

  // burst of random length, gap of random length
  task automatic send_bursty(particle_t p, ref int burst_left);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send_particle(p, 1'b1);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($urandom_range(0, 32'h00FFFFFF)) - 32'h00800000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return 32'($urandom_range(0, 32'h00200000)) - 32'h00100000;
    endcase
  endfunction

  function automatic particle_t rnd_particle();
    particle_t p;
    p.px = rnd_coord(); p.py = rnd_coord(); p.pz = rnd_coord();
    p.vx = rnd_coord(); p.vy = rnd_coord(); p.vz = rnd_coord();
    p.ts = ($urandom_range(0, 7) == 0) ? $urandom()
         : 32'($urandom_range(0, 32'h00080000)) - 32'h00040000;
    return p;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    crossing_t exp_c;
    if (rst_ni && done_o) begin
      if (crossings_pending.size() == 0) begin
        $error("crossing word with nothing expected");
        failures++;
      end else begin
        exp_c = crossings_pending.pop_front();
        if (crossing_found_o !== exp_c.found) begin
          $error("crossing_found exp %0d got %0d", exp_c.found, crossing_found_o);
          failures++;
        end
        if (crossing_time_o !== exp_c.tm) begin
          $error("crossing_time exp %0d got %0d", exp_c.tm, crossing_time_o);
          failures++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    int burst_left;
    int phase;
    slope_q = 0; rad0_q = 0; t0_q = 0; t1_q = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: zero radius and zero end time
    row.typed = 1'b1;
    row.p = '0; row.want = '0; rows = {rows, row};
    // crossing one time unit later lies past the zero step end
    row.p = '{32'sh10000, 0, 0, 32'shFFFF0000, 0, 0, 0};
    row.want = '0; rows = {rows, row};
    row.p = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0};
    row.want = '0; rows = {rows, row};
    row.p = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000};
    row.want = '0; rows = {rows, row};
    row.typed = 1'b0;
    row.p = '{32'sh10000, 0, 0, 32'sh8000, 0, 0, 32'h7FFFFFFF}; rows = {rows, row};
    row.p = '{32'shFFFFFFFF, -1, -1, -1, -1, -1, 32'shFFFFFFFF}; rows = {rows, row};
    foreach (rows[i]) begin
      send_particle(rows[i].p, i != rows.size() - 1);
      if (rows[i].typed) crossings_pending[$] = rows[i].want;
    end
    wait_idle();

    // growing bubble, particle inside moving out and outside moving in
    set_bubble(32'sh8000, 32'sh50000, 0, 32'sh100000);
    send_particle('{32'sh10000, 0, 0, 32'sh10000, 0, 0, 0}, 1);
    send_particle('{32'sh100000, 0, 0, 32'shFFFF0000, 0, 0, 32'sh10000}, 1);
    send_particle('{0, 32'sh20000, 0, 0, 0, 0, 0}, 1);
    send_particle('{32'sh400000, 0, 0, 32'sh10000, 0, 0, 0}, 1);
    send_particle('{32'sh30000, 32'sh30000, 0, 0, 32'sh10000, 0, 32'shFFFF0000}, 0);
    wait_idle();
    // shrinking bubble and extreme registers
    set_bubble(32'shFFFF8000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_particle('{0, 0, 0, 0, 0, 0, 0}, 1);
    send_particle('{32'sh10000, 0, 0, 32'sh10000, 0, 0, 32'h7FFFFFFF}, 1);
    send_particle('{32'sh200000, 0, 0, 0, 32'sh20000, 0, 0}, 0);
    wait_idle();
    set_bubble(32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000);
    send_particle('{32'sh10000, 0, 0, 0, 0, 0, 0}, 1);
    send_particle('{32'sh10000, 0, 0, 32'sh10000, 0, 0, 32'h80000000}, 0);
    wait_idle();

    // random phases over several bubble settings
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_bubble(32'sh10000, 32'sh20000, 0, 32'sh40000);
        1: set_bubble(32'sh8000, 32'sh100000, 32'shFFFC0000, 32'sh7FFFFFFF);
        2: set_bubble(32'sh0, 32'sh80000, 0, 32'sh200000);
        3: set_bubble(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        default: set_bubble(32'($urandom_range(0, 32'h40000)) - 32'h20000,
                            $urandom_range(0, 32'h00400000),
                            32'($urandom_range(0, 32'h40000)) - 32'h20000,
                            ($urandom_range(0, 3) == 0) ? $urandom()
                              : $urandom_range(0, 32'h00400000));
      endcase
      burst_left = 0;
      for (int i = 0; i < NumRandom / 8; i++) send_bursty(rnd_particle(), burst_left);
      start_i <= 1'b0;
      wait_idle();
    end

    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
